>>> src/sle_pkg.sv
package sle_pkg;

  // List geometry.
  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  // Fixed field widths.
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  // Common width for comparing a position against the length.
  localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_LOCATE    = 3'd3,
    CMD_RANGE_DEL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_RANGE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROT,
    OP_SHL,
    OP_SHR
  } cell_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] range_low;
    logic signed [WORD_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
  } out_item_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  bnd;
    logic [WORD_W-1:0] ins;
  } chain_ctl_t;

endpackage

>>> src/sle_cell.sv
module sle_cell (
  input  logic                            clk,
  input  logic [sle_pkg::IDX_W-1:0]       idx,
  input  sle_pkg::chain_ctl_t             ctl,
  input  logic [sle_pkg::WORD_W-1:0]      from_left,
  input  logic [sle_pkg::WORD_W-1:0]      from_right,
  output logic [sle_pkg::WORD_W-1:0]      data
);

  logic [sle_pkg::WORD_W-1:0] data_r;
  logic [sle_pkg::WORD_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      sle_pkg::OP_ROT: begin
        data_nxt = from_right;
      end
      sle_pkg::OP_SHL: begin
        if (idx >= ctl.bnd) begin
          data_nxt = from_right;
        end
      end
      sle_pkg::OP_SHR: begin
        if (idx > ctl.bnd) begin
          data_nxt = from_left;
        end else if (idx == ctl.bnd) begin
          data_nxt = ctl.ins;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> src/sle_chain.sv
module sle_chain (
  input  logic                        clk,
  input  sle_pkg::chain_ctl_t         ctl,
  output logic [sle_pkg::WORD_W-1:0]  head
);

  logic [sle_pkg::WORD_W-1:0] cell_data [sle_pkg::MAX_LEN];

  // The cells form a ring: rotation moves every word one place towards cell 0,
  // and cell 0 wraps round to the last cell.
  for (genvar g = 0; g < sle_pkg::MAX_LEN; g++) begin : g_cell
    sle_cell u_cell (
      .clk        (clk),
      .idx        (sle_pkg::IDX_W'(g)),
      .ctl        (ctl),
      .from_left  (cell_data[(g + sle_pkg::MAX_LEN - 1) % sle_pkg::MAX_LEN]),
      .from_right (cell_data[(g + 1) % sle_pkg::MAX_LEN]),
      .data       (cell_data[g])
    );
  end

  assign head = cell_data[0];

endmodule

>>> src/sequential_list_engine_top.sv
// Packed list engine holding up to MAX_LEN signed 32-bit words in a ring of cells.
// Commands arrive on the in_ channel (valid/ready) as one packed item; each
// command produces exactly one result transfer on the out_ channel.
// Insert shifts the tail up once, without rotating the ring. Delete, read,
// locate and range delete first rotate the whole ring once, watching cell 0
// to find the word at a position, the first match or the bounds of the run to
// remove. Delete then shifts the tail down once; range delete shifts it down
// once per removed word. Commands that fail their checks skip the ring and go
// straight to their result. One command is worked on at a time; the next input
// transfer is taken as soon as the engine is idle, even while the previous
// result still waits in the output register. A stalled receiver holds that
// result, and a finished command then waits until the output register is free.
// After reset the list is empty; the cell contents are not cleared, as words
// beyond the list length are never observed.
module sequential_list_engine_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sle_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sle_pkg::out_item_t   out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  localparam int IW = sle_pkg::IDX_W;
  localparam int LW = sle_pkg::LEN_W;
  localparam int CW = sle_pkg::CMP_W;
  localparam int WW = sle_pkg::WORD_W;
  localparam int PW = sle_pkg::POS_W;

  // Control state.
  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [LW-1:0]   len_r, len_nxt;

  // Command held for the duration of its work.
  logic [sle_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic signed [WW-1:0]      value_r, value_nxt;
  logic signed [WW-1:0]      lo_r, lo_nxt;
  logic signed [WW-1:0]      hi_r, hi_nxt;
  logic [IW-1:0]             bnd_r, bnd_nxt;

  // Scan and shift bookkeeping.
  logic [IW-1:0]   k_r, k_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   l_r, l_nxt;
  logic [LW-1:0]   r_r, r_nxt;
  logic            l_found_r, l_found_nxt;
  logic            r_found_r, r_found_nxt;
  logic            f_found_r, f_found_nxt;

  // Result being built.
  sle_pkg::status_t   status_r, status_nxt;
  logic signed [WW-1:0] rd_r, rd_nxt;
  logic [PW-1:0]      found_r, found_nxt;
  sle_pkg::out_item_t out_data_r, out_data_nxt;

  // Ring interface.
  sle_pkg::chain_ctl_t ctl;
  logic [WW-1:0]       head;

  // Comparison helpers.
  logic [CW-1:0]        pos_x;
  logic [CW-1:0]        len_x;
  logic                 in_xfer;
  logic [LW-1:0]        k_ext;
  logic                 in_list;
  logic signed [WW-1:0] head_s;
  logic                 head_lt_lo;
  logic                 head_gt_hi;
  logic                 l_hit;
  logic                 r_hit;
  logic                 scan_last;
  logic [LW-1:0]        l_fin;
  logic [LW-1:0]        r_fin;

  sle_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_x = CW'(in_data.position);
  assign len_x = CW'(len_r);

  // During a rotation cell 0 shows the word at list index k_r.
  assign k_ext      = LW'(k_r);
  assign in_list    = (k_ext < len_r);
  assign head_s     = signed'(head);
  assign head_lt_lo = (head_s < lo_r);
  assign head_gt_hi = (head_s > hi_r);
  assign scan_last  = (k_r == IW'(sle_pkg::MAX_LEN - 1));

  // The run to remove starts at the first word not below the low bound and ends
  // before the next word above the high bound.
  assign l_hit = in_list && !l_found_r && !head_lt_lo;
  assign r_hit = in_list && (l_found_r || !head_lt_lo) && !r_found_r && head_gt_hi;
  assign l_fin = l_hit ? k_ext : l_r;
  assign r_fin = r_hit ? k_ext : r_r;

  always_comb begin
    ctl.bnd = bnd_r;
    ctl.ins = value_r;
    ctl.op  = sle_pkg::OP_HOLD;
    if (state_r == S_SCAN) begin
      ctl.op = sle_pkg::OP_ROT;
    end else if ((state_r == S_SHIFT) && (cnt_r != '0)) begin
      ctl.op = (cmd_r == sle_pkg::CMD_INSERT) ? sle_pkg::OP_SHR : sle_pkg::OP_SHL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bnd_nxt       = bnd_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    l_found_nxt   = l_found_r;
    r_found_nxt   = r_found_r;
    f_found_nxt   = f_found_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    found_nxt     = found_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt     = in_data.cmd;
          value_nxt   = in_data.value;
          lo_nxt      = in_data.range_low;
          hi_nxt      = in_data.range_high;
          bnd_nxt     = IW'(pos_x - CW'(1));
          k_nxt       = '0;
          cnt_nxt     = LW'(1);
          l_nxt       = len_r;
          r_nxt       = len_r;
          l_found_nxt = 1'b0;
          r_found_nxt = 1'b0;
          f_found_nxt = 1'b0;
          status_nxt  = sle_pkg::ST_OK;
          rd_nxt      = '0;
          found_nxt   = '0;
          state_nxt   = S_FIN;
          unique case (in_data.cmd) inside
            sle_pkg::CMD_INSERT: begin
              if ((pos_x == '0) || (pos_x > len_x + CW'(1))) begin
                status_nxt = sle_pkg::ST_BAD_POS;
              end else if (len_r == LW'(sle_pkg::MAX_LEN)) begin
                status_nxt = sle_pkg::ST_FULL;
              end else begin
                len_nxt   = len_r + LW'(1);
                state_nxt = S_SHIFT;
              end
            end
            sle_pkg::CMD_DELETE, sle_pkg::CMD_READ: begin
              if ((pos_x == '0) || (pos_x > len_x)) begin
                status_nxt = sle_pkg::ST_BAD_POS;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            sle_pkg::CMD_LOCATE: begin
              state_nxt = S_SCAN;
            end
            sle_pkg::CMD_RANGE_DEL: begin
              if (len_r == '0) begin
                status_nxt = sle_pkg::ST_EMPTY;
              end else if (!(in_data.range_low < in_data.range_high)) begin
                status_nxt = sle_pkg::ST_BAD_RANGE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        k_nxt = k_r + IW'(1);
        if (l_hit) begin
          l_nxt       = k_ext;
          l_found_nxt = 1'b1;
        end
        if (r_hit) begin
          r_nxt       = k_ext;
          r_found_nxt = 1'b1;
        end
        if ((k_r == bnd_r) &&
            ((cmd_r == sle_pkg::CMD_DELETE) || (cmd_r == sle_pkg::CMD_READ))) begin
          rd_nxt = head_s;
        end
        if ((cmd_r == sle_pkg::CMD_LOCATE) && in_list && !f_found_r &&
            (head_s == value_r)) begin
          f_found_nxt = 1'b1;
          found_nxt   = PW'(k_ext + LW'(1));
        end
        if (scan_last) begin
          state_nxt = S_FIN;
          if (cmd_r == sle_pkg::CMD_DELETE) begin
            len_nxt   = len_r - LW'(1);
            cnt_nxt   = LW'(1);
            state_nxt = S_SHIFT;
          end else if (cmd_r == sle_pkg::CMD_RANGE_DEL) begin
            cnt_nxt   = r_fin - l_fin;
            len_nxt   = len_r - (r_fin - l_fin);
            bnd_nxt   = IW'(l_fin);
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - LW'(1);
        end
        if ((cnt_r == '0) || (cnt_r == LW'(1))) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status         = status_r;
          out_data_nxt.read_value     = rd_r;
          out_data_nxt.found_position = found_r;
          out_data_nxt.list_length    = PW'(len_r);
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    value_r    <= value_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    bnd_r      <= bnd_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    l_found_r  <= l_found_nxt;
    r_found_r  <= r_found_nxt;
    f_found_r  <= f_found_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    found_r    <= found_nxt;
  end

`ifndef NO_ASSERTIONS
  // The list never holds more words than there are cells.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(sle_pkg::MAX_LEN))
    else $error("list length exceeds capacity");

  // A command in progress blocks the next input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // The start of the run to remove never lies beyond its end.
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (l_r <= r_r))
    else $error("range run bounds out of order");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && !out_ready |=> (state_r == S_FIN))
    else $error("result loaded over a stalled transfer");
`endif

endmodule
